>>> src/stereo_disparity_cost_unit_defines.svh
// Assertion macros shared by the disparity cost unit.
`ifndef STEREO_DISPARITY_COST_UNIT_DEFINES_SVH
`define STEREO_DISPARITY_COST_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SDC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/sdc_pkg.sv
// Package of the disparity cost unit: field widths, payload types and constants.
`timescale 1ns / 1ps
`default_nettype none
package sdc_pkg;

    localparam int MAX_DISPARITIES_DEF = 64;
    localparam int COST_DIVISOR        = 10;
    localparam int SAD_LIMIT           = 766;

    localparam int PIX_W   = 8;
    localparam int SAD_W   = 10;
    localparam int COST_W  = 16;
    localparam int DISP_W  = 6;
    localparam int COUNT_W = 7;
    localparam int ROM_AW  = $clog2(SAD_LIMIT);

    localparam logic [SAD_W-1:0]   SAD_INIT   = 10'd1023;
    localparam logic [SAD_W-1:0]   SAD_MAX    = 10'(SAD_LIMIT - 1);
    localparam logic [COST_W-1:0]  ONE_Q15    = 16'h8000;
    localparam logic [COUNT_W-1:0] COUNT_RST  = 7'd30;
    localparam logic [COST_W-1:0]  FLOOR_RST  = 16'd33;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPARITY_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COST_FLOOR      = 2'd1;

    typedef struct packed {
        logic [PIX_W-1:0] left_red;
        logic [PIX_W-1:0] left_green;
        logic [PIX_W-1:0] left_blue;
        logic [PIX_W-1:0] right_red;
        logic [PIX_W-1:0] right_green;
        logic [PIX_W-1:0] right_blue;
    } t_in_item;

    typedef struct packed {
        logic [DISP_W-1:0] disparity;
        logic [COST_W-1:0] cost;
        logic              last;
    } t_out_item;

endpackage
`default_nettype wire

>>> src/sdc_cost_rom.sv
// Exponential cost table with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module sdc_cost_rom (
    input  wire logic                          i_clk,
    input  wire logic [sdc_pkg::ROM_AW-1:0]    i_addr,
    output logic      [sdc_pkg::COST_W-1:0]    o_data
);

    typedef logic [sdc_pkg::COST_W-1:0] t_cost_table [sdc_pkg::SAD_LIMIT];

    // Shift-and-subtract quotient, used only while the table is being built.
    function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-1/COST_DIVISOR) is formed in Q0.32 from its alternating series,
    // then raised to successive powers with rounding and cut to Q1.15.
    function automatic t_cost_table build_cost_rom();
        logic [63:0]  term;
        logic [63:0]  pos;
        logic [63:0]  neg;
        logic [63:0]  base;
        logic [63:0]  p;
        logic [127:0] prod;
        t_cost_table  rom;
        term = 64'd1 << 32;
        pos  = term;
        neg  = '0;
        for (int n = 1; n < 64; n++) begin
            if (term != 0) begin
                term = div_u64(term, 64'(n) * 64'(sdc_pkg::COST_DIVISOR));
                if (n % 2 == 1) begin
                    neg = neg + term;
                end else begin
                    pos = pos + term;
                end
            end
        end
        base = pos - neg;
        if (base > 64'hFFFF_FFFF) begin
            base = 64'hFFFF_FFFF;
        end
        p = 64'd1 << 32;
        for (int d = 0; d < sdc_pkg::SAD_LIMIT; d++) begin
            if (d > 0) begin
                prod = 128'(p) * 128'(base) + (128'd1 << 31);
                p    = prod[95:32];
            end
            rom[d] = 16'((p + (64'd1 << 16)) >> 17);
        end
        return rom;
    endfunction

    localparam t_cost_table COST_ROM = build_cost_rom();

    always_ff @(posedge i_clk) begin
        o_data <= COST_ROM[i_addr];
    end

endmodule
`default_nettype wire

>>> src/stereo_disparity_cost_unit.sv
// Top level of the stereo disparity cost unit.
`timescale 1ns / 1ps
`default_nettype none
`include "stereo_disparity_cost_unit_defines.svh"
// One left pixel is matched against disparity_count candidate right pixels, one
// item each. An item is taken when start is high and busy is low; each item
// occupies the block for a capture step and then a store step (SAD store and
// minimum update through the shared subtractor), after which a non-final item
// may follow. After the final item of a run, busy stays high through the emit
// and drain states: costs leave one per cycle, in disparity order, through the
// SAD memory read, the shared subtractor and the registered cost table, each
// shown for exactly one cycle with o_result_strobe and no back-pressure. The
// last cost of a pixel carries last set. Configuration writes are always ready
// and must only be made while busy is low and no costs are outstanding.
module stereo_disparity_cost_unit #(
    parameter int MAX_DISPARITIES = sdc_pkg::MAX_DISPARITIES_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire sdc_pkg::t_in_item                 i_item,
    output logic                                   o_result_strobe,
    output sdc_pkg::t_out_item                     o_result,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [sdc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [sdc_pkg::COST_W-1:0]        i_cfg_data
);

    localparam int IW = $clog2(MAX_DISPARITIES);
    localparam int CW = $clog2(MAX_DISPARITIES + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_STORE = 4'b0010,
        ST_EMIT  = 4'b0100,
        ST_DRAIN = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [sdc_pkg::COUNT_W-1:0] r_cfg_count;
    logic [sdc_pkg::COST_W-1:0]  r_cfg_floor;

    logic [sdc_pkg::SAD_W-1:0]   r_sad, n_sad;
    logic [IW-1:0]               r_slot, n_slot;
    logic [sdc_pkg::SAD_W-1:0]   r_min, n_min;
    logic [IW-1:0]               r_last_idx, n_last_idx;
    logic [IW-1:0]               r_k, n_k;

    logic [sdc_pkg::SAD_W-1:0]   r_sad_mem [MAX_DISPARITIES];
    logic [sdc_pkg::SAD_W-1:0]   r_rd_sad;

    logic                        r_v1, r_v2;
    logic [IW-1:0]               r_idx1, r_idx2;
    logic                        r_last1, r_last2;

    logic                        r_out_strobe;
    sdc_pkg::t_out_item          r_out;

    logic [CW-1:0]               w_n_eff;
    logic                        w_run_end;
    logic [sdc_pkg::COST_W-1:0]  w_floor;
    logic [sdc_pkg::SAD_W-1:0]   w_sub_a;
    logic [sdc_pkg::SAD_W:0]     w_sub;
    logic [sdc_pkg::SAD_W-1:0]   w_diff;
    logic [sdc_pkg::COST_W-1:0]  w_rom_data;
    logic [sdc_pkg::COST_W-1:0]  w_cost;
    logic                        w_accept;

    // Effective count and floor after range limiting.
    always_comb begin
        if (r_cfg_count == '0) begin
            w_n_eff = CW'(1);
        end else if (r_cfg_count > sdc_pkg::COUNT_W'(MAX_DISPARITIES)) begin
            w_n_eff = CW'(MAX_DISPARITIES);
        end else begin
            w_n_eff = CW'(r_cfg_count);
        end
        w_floor   = (r_cfg_floor > sdc_pkg::ONE_Q15) ? sdc_pkg::ONE_Q15 : r_cfg_floor;
        w_run_end = (CW'(r_slot) + CW'(1)) >= w_n_eff;
    end

    assign w_accept    = start && !busy;
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // Sum of absolute RGB differences of the item being taken.
    always_comb begin
        logic [sdc_pkg::PIX_W-1:0] ad_r;
        logic [sdc_pkg::PIX_W-1:0] ad_g;
        logic [sdc_pkg::PIX_W-1:0] ad_b;
        ad_r = (i_item.left_red > i_item.right_red) ?
               i_item.left_red - i_item.right_red : i_item.right_red - i_item.left_red;
        ad_g = (i_item.left_green > i_item.right_green) ?
               i_item.left_green - i_item.right_green : i_item.right_green - i_item.left_green;
        ad_b = (i_item.left_blue > i_item.right_blue) ?
               i_item.left_blue - i_item.right_blue : i_item.right_blue - i_item.left_blue;
        n_sad = sdc_pkg::SAD_W'(ad_r) + sdc_pkg::SAD_W'(ad_g) + sdc_pkg::SAD_W'(ad_b);
    end

    // Shared subtractor: new SAD against the minimum while storing, stored SAD
    // against the minimum while emitting. The borrow doubles as the compare.
    always_comb begin
        w_sub_a = (r_state == ST_STORE) ? r_sad : r_rd_sad;
        w_sub   = {1'b0, w_sub_a} - {1'b0, r_min};
        if (w_sub[sdc_pkg::SAD_W]) begin
            w_diff = '0;
        end else if (w_sub[sdc_pkg::SAD_W-1:0] > sdc_pkg::SAD_MAX) begin
            w_diff = sdc_pkg::SAD_MAX;
        end else begin
            w_diff = w_sub[sdc_pkg::SAD_W-1:0];
        end
    end

    sdc_cost_rom u_cost_rom (
        .i_clk  (i_clk),
        .i_addr (sdc_pkg::ROM_AW'(w_diff)),
        .o_data (w_rom_data)
    );

    assign w_cost = (w_rom_data < w_floor) ? w_floor : w_rom_data;

    // Sequencer.
    always_comb begin
        n_state    = r_state;
        n_slot     = r_slot;
        n_min      = r_min;
        n_last_idx = r_last_idx;
        n_k        = r_k;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_STORE;
                end
            end
            ST_STORE: begin
                if (w_sub[sdc_pkg::SAD_W]) begin
                    n_min = r_sad;
                end
                if (w_run_end) begin
                    n_state    = ST_EMIT;
                    n_slot     = '0;
                    n_k        = '0;
                    n_last_idx = IW'(w_n_eff - CW'(1));
                end else begin
                    n_state = ST_IDLE;
                    n_slot  = r_slot + IW'(1);
                end
            end
            ST_EMIT: begin
                if (r_k == r_last_idx) begin
                    n_state = ST_DRAIN;
                    n_k     = '0;
                end else begin
                    n_k = r_k + IW'(1);
                end
            end
            ST_DRAIN: begin
                // The minimum is still in use until the last entry has passed
                // the subtractor.
                if (!r_v1 && !r_v2) begin
                    n_state = ST_IDLE;
                    n_min   = sdc_pkg::SAD_INIT;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cfg_count  <= sdc_pkg::COUNT_RST;
            r_cfg_floor  <= sdc_pkg::FLOOR_RST;
            r_slot       <= '0;
            r_min        <= sdc_pkg::SAD_INIT;
            r_last_idx   <= '0;
            r_k          <= '0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_out_strobe <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_slot       <= n_slot;
            r_min        <= n_min;
            r_last_idx   <= n_last_idx;
            r_k          <= n_k;
            r_v1         <= (r_state == ST_EMIT);
            r_v2         <= r_v1;
            r_out_strobe <= r_v2;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == sdc_pkg::CFG_DISPARITY_COUNT) begin
                    r_cfg_count <= i_cfg_data[sdc_pkg::COUNT_W-1:0];
                end else if (i_cfg_index == sdc_pkg::CFG_COST_FLOOR) begin
                    r_cfg_floor <= i_cfg_data;
                end
            end
        end
    end

    // Payload registers and the SAD memory.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sad <= n_sad;
        end
        r_idx1          <= r_k;
        r_last1         <= (r_k == r_last_idx);
        r_idx2          <= r_idx1;
        r_last2         <= r_last1;
        r_out.disparity <= sdc_pkg::DISP_W'(r_idx2);
        r_out.cost      <= w_cost;
        r_out.last      <= r_last2;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_STORE) begin
            r_sad_mem[r_slot] <= r_sad;
        end
        r_rd_sad <= r_sad_mem[r_k];
    end

    assign o_result_strobe = r_out_strobe;
    assign o_result        = r_out;

    `SDC_ASSERT_NEXT(a_accept_to_store, i_clk, i_rst_n, w_accept, r_state == ST_STORE, "accepted transaction did not reach the store step")
    `SDC_ASSERT_SAME(a_strobe_in_emit, i_clk, i_rst_n, o_result_strobe, r_state == ST_EMIT || r_state == ST_DRAIN, "result strobe outside emission")
    `SDC_ASSERT_NEXT(a_last_ends_run, i_clk, i_rst_n, o_result_strobe && o_result.last, r_state == ST_IDLE && r_min == sdc_pkg::SAD_INIT, "run not closed after last result")
    `SDC_ASSERT_SAME(a_idle_fresh_min, i_clk, i_rst_n, r_state == ST_IDLE && r_slot == '0, r_min == sdc_pkg::SAD_INIT, "minimum not reset at start of run")

endmodule
`default_nettype wire
